// ===== rtl/core/sbda_pkg.sv =====
// ---------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Character codes, output packing widths and controller/datapath links for
// the signed binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package sbda_pkg;

  localparam int VALUE_WIDTH_DEF = 16;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 3;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // decimal digits needed for the largest magnitude, 2^(width-1)
  function automatic int dec_digits(input int width);
    longint unsigned v;
    int              n;
    v = 64'd1 << (width - 1);
    n = 0;
    while (v != 0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load;   // take a new word, clear the BCD register
    logic shift;  // one add-3 and shift step
    logic strip;  // drop a leading zero digit
    logic pop;    // advance to the next character
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero;   // most significant digit still held is zero
    logic one_digit;  // only one digit left
    logic last;       // character on the output is the final one
  } stat_t;

endpackage

// ===== rtl/core/sbda_ctrl.sv =====
// ---------------------------------------------------------------------------
// sbda_ctrl: conversion sequencer
// Steps the datapath through load, one shift per input bit, leading zero
// removal and character output.
// ---------------------------------------------------------------------------
module sbda_ctrl #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  sbda_pkg::stat_t stat,
  output sbda_pkg::cmd_t  cmd
);

  localparam int BCW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  state_t         state;
  logic [BCW-1:0] bit_cnt;

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && s_tvalid;
    cmd.shift = (state == ST_CONV);
    cmd.strip = (state == ST_STRIP) && stat.top_zero && !stat.one_digit;
    cmd.pop   = (state == ST_EMIT) && m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
      bit_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state    <= ST_CONV;
            s_tready <= 1'b0;
            bit_cnt  <= BCW'(VALUE_WIDTH - 1);
          end
        end
        ST_CONV: begin
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= ST_STRIP;
          end
        end
        ST_STRIP: begin
          if (!(stat.top_zero && !stat.one_digit)) begin
            state    <= ST_EMIT;
            m_tvalid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (m_tready && stat.last) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sbda_dp.sv =====
// ---------------------------------------------------------------------------
// sbda_dp: conversion datapath
// Magnitude and BCD shift registers (shift-add-3), digit and sign tracking,
// output character formation.
// ---------------------------------------------------------------------------
module sbda_dp #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic [VALUE_WIDTH-1:0]           value,
  input  sbda_pkg::cmd_t                   cmd,
  output sbda_pkg::stat_t                  stat,
  output logic [sbda_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                             out_last
);

  localparam int NDIG = sbda_pkg::dec_digits(VALUE_WIDTH);
  localparam int BW   = 4 * NDIG;
  localparam int DCW  = $clog2(NDIG + 1);
  localparam int PADW = sbda_pkg::OUT_TDATA_W - sbda_pkg::CHAR_W - sbda_pkg::LEN_W;

  logic [VALUE_WIDTH-1:0]    mag;
  logic [BW-1:0]             bcd;
  logic [BW-1:0]             bcd_adj;
  logic                      sign_pend;
  logic [DCW-1:0]            rem;
  logic [sbda_pkg::LEN_W-1:0] len;
  logic [3:0]                top;
  logic [sbda_pkg::CHAR_W-1:0] ch;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag       <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      bcd       <= '0;
      sign_pend <= value[VALUE_WIDTH-1];
      rem       <= DCW'(NDIG);
      len       <= sbda_pkg::LEN_W'(NDIG) + {{(sbda_pkg::LEN_W-1){1'b0}}, value[VALUE_WIDTH-1]};
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BW-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.strip) begin
      bcd <= bcd << 4;
      rem <= rem - 1'b1;
      len <= len - 1'b1;
    end else if (cmd.pop) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        bcd <= bcd << 4;
        rem <= rem - 1'b1;
      end
    end
  end

  assign top = bcd[BW-1 -: 4];
  assign ch  = sign_pend ? sbda_pkg::CHAR_MINUS : (sbda_pkg::CHAR_ZERO + {4'b0000, top});

  assign stat.top_zero  = (top == 4'd0);
  assign stat.one_digit = (rem == DCW'(1));
  assign stat.last      = !sign_pend && (rem == DCW'(1));

  assign out_data = {{PADW{1'b0}}, len, ch};
  assign out_last = stat.last;

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement word into its decimal text, one character
// per output word, most significant first.
// ---------------------------------------------------------------------------
// One input word is taken at a time. After acceptance the datapath runs a
// shift-add-3 (double dabble) pass with one shift per input bit, then
// removes leading zero digits one at a time, then offers the characters one
// per cycle as the sink takes them; s_tready returns the cycle after the
// last character is taken. Negative values begin with '-'; the most negative
// value is shown as its true magnitude (-32768 gives "-32768"). Zero gives
// a single '0'. Every output word carries the run length and tlast marks
// the final character; no terminating NUL is sent. From 21 bits up the run
// length can exceed 7 and is reported modulo 8.
// ---------------------------------------------------------------------------
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input word
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [VALUE_WIDTH-1:0] value
  // output word
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sbda_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [7:0] ascii_char, [10:8] text_length
  output logic                                m_tlast    // last character of the run
);

  sbda_pkg::cmd_t  cmd;
  sbda_pkg::stat_t stat;

  // sequencer: owns the handshakes and the bit counter
  sbda_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: bits above VALUE_WIDTH in tdata are padding and ignored
  sbda_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .value    (s_tdata[VALUE_WIDTH-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

endmodule

// ===== rtl/core/sbda_checker.sv =====
// ---------------------------------------------------------------------------
// sbda_checker: port-level checks
// Watches the converter's ports for sequencing and character range.
// ---------------------------------------------------------------------------
module sbda_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [sbda_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);

  // never accepting and emitting at once
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // one word in flight: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held after accept");

  // run ends cleanly on tlast
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("output continued past last character");

  // characters are a minus sign or a decimal digit
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:0] == sbda_pkg::CHAR_MINUS) ||
                  ((m_tdata[7:0] >= 8'h30) && (m_tdata[7:0] <= 8'h39))))
    else $error("output character out of range");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/tb_signed_binary_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii: self-checking bench for the converter
// Sends signed words through the input stream in random bursts and checks
// each character word against a decimal text predictor while the sink
// stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii;

  localparam int W          = sbda_pkg::VALUE_WIDTH_DEF;
  localparam int IN_W       = ((W + 7) / 8) * 8;
  localparam int CW         = sbda_pkg::CHAR_W;
  localparam int LW         = sbda_pkg::LEN_W;
  localparam int OW         = sbda_pkg::OUT_TDATA_W;
  localparam int SETTLE     = 60;   // wait after the last character is taken
  localparam int IDLE_LIMIT = 600;  // cycles with no word moving on either side
  localparam int N_RANDOM   = 108;

  typedef struct packed {
    logic [CW-1:0] ch;
    logic [LW-1:0] len;
    logic          last;
  } text_char_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OW-1:0]   m_tdata;
  logic            m_tlast;

  logic [W-1:0] pending_words[$];   // words still to send
  text_char_t   expected_chars[$];  // characters predicted, oldest first

  int errors     = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int idle_count = 0;
  int stall_mode = 0;
  int mode_timer = 0;
  text_char_t got;

  signed_binary_to_decimal_ascii #(.VALUE_WIDTH(W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [W-1:0] value
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] ascii_char, [10:8] text_length
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decimal text of one signed word: optional '-', digits without leading
  // zeros, length on every character, last flag on the final digit.
  // The most negative value negates to its own bit pattern, read unsigned.
  function automatic void predict_decimal_text(input logic [W-1:0] value);
    logic            negative;
    logic [W-1:0]    mag_bits;
    longint unsigned mag;
    int              digit[12];
    int              n;
    int              total;
    negative = value[W-1];
    mag_bits = negative ? (~value + 1'b1) : value;
    mag      = mag_bits;
    n        = 0;
    do begin
      digit[n] = int'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    total = n + (negative ? 1 : 0);
    if (negative)
      expected_chars.push_back('{sbda_pkg::CHAR_MINUS, LW'(total), 1'b0});
    for (int d = n - 1; d >= 0; d--)
      expected_chars.push_back('{sbda_pkg::CHAR_ZERO + CW'(digit[d]), LW'(total), d == 0});
  endfunction

  // Driver: bursts of random length, random gaps between them. A new word
  // goes up only when the line is free, so tvalid holds across a stall.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predict_decimal_text(s_tdata[W-1:0]);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_W'(pending_words.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character word, then pick the next ready level.
  // Stall mode is redrawn each time mode_timer wraps: always ready, coin flip, mostly stalled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word tdata=%h tlast=%b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          got = expected_chars.pop_front();
          if (m_tdata[CW-1:0] !== got.ch) begin
            $display("%0t: ascii_char expected %h actual %h", $time, got.ch,
                     m_tdata[CW-1:0]);
            errors++;
          end
          if (m_tdata[CW+LW-1:CW] !== got.len) begin
            $display("%0t: text_length expected %0d actual %0d", $time, got.len,
                     m_tdata[CW+LW-1:CW]);
            errors++;
          end
          if (m_tlast !== got.last) begin
            $display("%0t: tlast expected %b actual %b", $time, got.last, m_tlast);
            errors++;
          end
          if (m_tdata[OW-1:CW+LW] !== '0) begin
            $display("%0t: tdata pad expected 0 actual %h", $time,
                     m_tdata[OW-1:CW+LW]);
            errors++;
          end
        end
      end
      mode_timer++;
      if (mode_timer >= 64) begin
        mode_timer = 0;
        stall_mode = $urandom_range(0, 2);
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int mag;
    int ndig;
    int lo;
    int hi;
    int p10;
    // directed: zero, one digit each sign, every length step, both extremes,
    // alternating bit patterns, inner zeros
    pending_words.push_back(W'(0));
    pending_words.push_back(W'(1));
    pending_words.push_back(W'(-1));
    pending_words.push_back(W'(9));
    pending_words.push_back(W'(-9));
    pending_words.push_back(W'(10));
    pending_words.push_back(W'(-10));
    pending_words.push_back(W'(99));
    pending_words.push_back(W'(100));
    pending_words.push_back(W'(-999));
    pending_words.push_back(W'(1000));
    pending_words.push_back(W'(9999));
    pending_words.push_back(W'(-10000));
    pending_words.push_back(W'(10001));
    pending_words.push_back(W'(32767));
    pending_words.push_back(W'(-32768));
    pending_words.push_back(W'(-32767));
    pending_words.push_back(W'(12345));
    pending_words.push_back(W'(-30000));
    pending_words.push_back(16'h5555);
    pending_words.push_back(16'hAAAA);
    pending_words.push_back(W'(-2));

    // random: full range, small values, chosen digit counts, near boundaries
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: pending_words.push_back(W'($urandom_range(0, (1 << W) - 1)));
        1: begin
          mag = $urandom_range(0, 99);
          pending_words.push_back($urandom_range(0, 1) ? W'(-mag) : W'(mag));
        end
        2: begin
          ndig = $urandom_range(1, 5);
          lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
          hi   = 10 ** ndig - 1;
          if (hi > 32767) hi = 32767;
          mag  = $urandom_range(lo, hi);
          pending_words.push_back($urandom_range(0, 1) ? W'(-mag) : W'(mag));
        end
        default: begin
          p10 = 10 ** $urandom_range(0, 4);
          mag = p10 + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 4) == 0) mag = 32767 + $urandom_range(0, 1);
          pending_words.push_back($urandom_range(0, 1) ? W'(-mag) : W'(mag));
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sample at the falling edge so the driver's updates have settled
    while (pending_words.size() > 0 || s_tvalid) @(negedge clk);
    while (expected_chars.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbda_pkg.sv
rtl/core/sbda_ctrl.sv
rtl/core/sbda_dp.sv
rtl/core/signed_binary_to_decimal_ascii.sv
rtl/core/sbda_checker.sv
bench/tb_signed_binary_to_decimal_ascii.sv
